// ===== rtl/sslvl_pkg.sv =====
// Package for the soft-start level stepper.
// Holds field widths, power levels, reset values, saturation limits, the phase type and indexes.
// No dependencies; every other file of the block but the button interface uses it by scoped names.
package sslvl_pkg;

    // Field and state widths
    localparam int unsigned WIDTH_W   = 16;
    localparam int unsigned LEVEL_W   = 3;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned PRESS_W   = 16;
    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 16;

    // Power levels
    localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;

    // Register reset values
    localparam logic [WIDTH_W-1:0] RST_RAMP_STEP      = 16'd100;
    localparam logic [TICK_W-1:0]  RST_RAMP_INTERVAL  = 8'd3;
    localparam logic [PRESS_W-1:0] RST_AUTO_OFF_LIMIT = 16'd18000;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_OFF      = 16'd8000;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_ONE      = 16'd9600;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_TWO      = 16'd10200;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_THREE    = 16'd11000;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_FOUR     = 16'd12000;

    // Saturation limits of the counters
    localparam logic [TICK_W-1:0]     TICK_MAX     = '1;
    localparam logic [PRESS_W-1:0]    PRESS_MAX    = '1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;

    // Press handling phase, one-hot
    typedef enum logic [2:0] {
        PHASE_IDLE     = 3'b001,
        PHASE_DEBOUNCE = 3'b010,
        PHASE_AWAIT    = 3'b100
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP      = 4'd0,
        CFG_RAMP_INTERVAL  = 4'd1,
        CFG_AUTO_OFF_LIMIT = 4'd2,
        CFG_WIDTH_OFF      = 4'd3,
        CFG_WIDTH_ONE      = 4'd4,
        CFG_WIDTH_TWO      = 4'd5,
        CFG_WIDTH_THREE    = 4'd6,
        CFG_WIDTH_FOUR     = 4'd7
    } cfg_idx_t;

endpackage

// ===== rtl/sslvl_button_if.sv =====
// Input channel of the soft-start level stepper: one sampled button level per item.
interface sslvl_button_if;
    logic valid;
    logic ready;
    logic button_pressed;

    modport source (output valid, output button_pressed, input ready);
    modport sink (input valid, input button_pressed, output ready);
endinterface

// ===== rtl/sslvl_status_if.sv =====
// Result channel of the soft-start level stepper: pulse width, level and busy flag.
// Depends on sslvl_pkg for the field widths.
interface sslvl_status_if;
    logic                               valid;
    logic                               ready;
    logic [sslvl_pkg::WIDTH_W-1:0]      pulse_width;
    logic [sslvl_pkg::LEVEL_W-1:0]      level;
    logic                               button_busy;

    modport source (output valid, output pulse_width, output level, output button_busy,
                    input ready);
    modport sink (input valid, input pulse_width, input level, input button_busy,
                  output ready);
endinterface

// ===== rtl/sslvl_cfg_if.sv =====
// Configuration write channel of the soft-start level stepper.
// Depends on sslvl_pkg for the index and data widths.
interface sslvl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sslvl_pkg::CFG_IDX_W-1:0]    index;
    logic [sslvl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/soft_start_level_stepper.sv =====
// Soft-start level stepper: debounced button steps a power level, the pulse width ramps
// toward the level's target. A result is registered, valid in the cycle after acceptance.
// Throughput: one item per cycle while results are taken; the single output register lets
// a new item enter in the same cycle that the waiting result is taken.
// Reset (rst_n, asynchronous, active low) puts level off, width 8000, counters at zero,
// the press phase idle and all configuration registers at their documented defaults.
module soft_start_level_stepper #(
    parameter int unsigned DEBOUNCE_TICKS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    sslvl_button_if.sink             button,
    sslvl_status_if.source           status,
    sslvl_cfg_if.sink                cfg
);

    localparam logic [sslvl_pkg::DEBOUNCE_W-1:0] DEBOUNCE_LIMIT =
        sslvl_pkg::DEBOUNCE_W'(DEBOUNCE_TICKS);

    // Configuration registers
    logic [sslvl_pkg::WIDTH_W-1:0]    ramp_step_reg;
    logic [sslvl_pkg::TICK_W-1:0]     ramp_interval_reg;
    logic [sslvl_pkg::PRESS_W-1:0]    auto_off_limit_reg;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_off_reg;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_one_reg;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_two_reg;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_three_reg;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_four_reg;

    // Block state
    logic [sslvl_pkg::LEVEL_W-1:0]    level_reg, level_next;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_reg, width_next;
    logic [sslvl_pkg::TICK_W-1:0]     step_ticks_reg, step_ticks_next;
    logic [sslvl_pkg::PRESS_W-1:0]    press_ticks_reg, press_ticks_next;
    sslvl_pkg::phase_t                phase_reg, phase_next;
    logic [sslvl_pkg::DEBOUNCE_W-1:0] debounce_reg, debounce_next;

    // Output register
    logic                             out_valid_reg, out_valid_next;
    logic [sslvl_pkg::WIDTH_W-1:0]    out_width_reg;
    logic [sslvl_pkg::LEVEL_W-1:0]    out_level_reg;
    logic                             out_busy_reg;

    logic                             accept;
    logic [sslvl_pkg::TICK_W-1:0]     step_ticks_inc;
    logic [sslvl_pkg::PRESS_W-1:0]    press_ticks_inc;
    logic [sslvl_pkg::DEBOUNCE_W-1:0] debounce_inc;
    logic [sslvl_pkg::WIDTH_W-1:0]    target;
    logic [sslvl_pkg::WIDTH_W:0]      width_up;
    logic [sslvl_pkg::WIDTH_W-1:0]    width_gap;

    // Handshakes
    assign cfg.ready    = 1'b1;
    assign button.ready = !out_valid_reg || status.ready;
    assign accept       = button.valid && button.ready;

    assign status.valid       = out_valid_reg;
    assign status.pulse_width = out_width_reg;
    assign status.level       = out_level_reg;
    assign status.button_busy = out_busy_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg      <= sslvl_pkg::RST_RAMP_STEP;
            ramp_interval_reg  <= sslvl_pkg::RST_RAMP_INTERVAL;
            auto_off_limit_reg <= sslvl_pkg::RST_AUTO_OFF_LIMIT;
            width_off_reg      <= sslvl_pkg::RST_WIDTH_OFF;
            width_one_reg      <= sslvl_pkg::RST_WIDTH_ONE;
            width_two_reg      <= sslvl_pkg::RST_WIDTH_TWO;
            width_three_reg    <= sslvl_pkg::RST_WIDTH_THREE;
            width_four_reg     <= sslvl_pkg::RST_WIDTH_FOUR;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                sslvl_pkg::CFG_RAMP_STEP:      ramp_step_reg      <= cfg.data;
                sslvl_pkg::CFG_RAMP_INTERVAL:  ramp_interval_reg  <= cfg.data[sslvl_pkg::TICK_W-1:0];
                sslvl_pkg::CFG_AUTO_OFF_LIMIT: auto_off_limit_reg <= cfg.data;
                sslvl_pkg::CFG_WIDTH_OFF:      width_off_reg      <= cfg.data;
                sslvl_pkg::CFG_WIDTH_ONE:      width_one_reg      <= cfg.data;
                sslvl_pkg::CFG_WIDTH_TWO:      width_two_reg      <= cfg.data;
                sslvl_pkg::CFG_WIDTH_THREE:    width_three_reg    <= cfg.data;
                sslvl_pkg::CFG_WIDTH_FOUR:     width_four_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    // Saturating tick counters
    assign step_ticks_inc  = (step_ticks_reg == sslvl_pkg::TICK_MAX) ? step_ticks_reg
                           : step_ticks_reg + 1'b1;
    assign press_ticks_inc = (press_ticks_reg == sslvl_pkg::PRESS_MAX) ? press_ticks_reg
                           : press_ticks_reg + 1'b1;
    assign debounce_inc    = (debounce_reg == sslvl_pkg::DEBOUNCE_MAX) ? debounce_reg
                           : debounce_reg + 1'b1;

    // Target width of the level held at the start of idle processing
    always_comb
    begin
        case (level_reg)
            sslvl_pkg::LEVEL_ONE:   target = width_one_reg;
            sslvl_pkg::LEVEL_TWO:   target = width_two_reg;
            sslvl_pkg::LEVEL_THREE: target = width_three_reg;
            sslvl_pkg::LEVEL_FOUR:  target = width_four_reg;
            default:                target = width_off_reg;
        endcase
    end

    assign width_up  = {1'b0, width_reg} + {1'b0, ramp_step_reg};
    assign width_gap = width_reg - target;

    // Per-item state update: press handling, then idle processing
    always_comb
    begin
        level_next       = level_reg;
        width_next       = width_reg;
        step_ticks_next  = step_ticks_inc;
        press_ticks_next = press_ticks_inc;
        phase_next       = phase_reg;
        debounce_next    = debounce_reg;

        case (phase_reg)
            sslvl_pkg::PHASE_DEBOUNCE:
            begin
                if (!button.button_pressed)
                begin
                    phase_next = sslvl_pkg::PHASE_IDLE;
                end
                else
                begin
                    debounce_next = debounce_inc;
                    if (debounce_inc >= DEBOUNCE_LIMIT)
                    begin
                        press_ticks_next = '0;
                        level_next = (level_reg >= sslvl_pkg::LEVEL_FOUR) ? sslvl_pkg::LEVEL_OFF
                                   : level_reg + 1'b1;
                        phase_next = sslvl_pkg::PHASE_AWAIT;
                    end
                end
            end
            sslvl_pkg::PHASE_AWAIT:
            begin
                if (!button.button_pressed)
                begin
                    phase_next = sslvl_pkg::PHASE_IDLE;
                end
            end
            default:
            begin
                phase_next = sslvl_pkg::PHASE_IDLE;
                if (button.button_pressed)
                begin
                    phase_next    = sslvl_pkg::PHASE_DEBOUNCE;
                    debounce_next = '0;
                end
            end
        endcase

        // Idle processing never follows an accepted press, so the level is unchanged here.
        if (phase_next == sslvl_pkg::PHASE_IDLE)
        begin
            if (level_reg != sslvl_pkg::LEVEL_OFF && press_ticks_inc > auto_off_limit_reg)
            begin
                level_next = sslvl_pkg::LEVEL_OFF;
            end
            if (step_ticks_inc >= ramp_interval_reg)
            begin
                step_ticks_next = '0;
                if (width_reg < target)
                begin
                    width_next = (width_up > {1'b0, target}) ? target
                               : width_up[sslvl_pkg::WIDTH_W-1:0];
                end
                else if (width_reg > target)
                begin
                    width_next = (width_gap < ramp_step_reg) ? target
                               : width_reg - ramp_step_reg;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= sslvl_pkg::LEVEL_OFF;
            width_reg       <= sslvl_pkg::RST_WIDTH_OFF;
            step_ticks_reg  <= '0;
            press_ticks_reg <= '0;
            phase_reg       <= sslvl_pkg::PHASE_IDLE;
            debounce_reg    <= '0;
        end
        else if (accept)
        begin
            level_reg       <= level_next;
            width_reg       <= width_next;
            step_ticks_reg  <= step_ticks_next;
            press_ticks_reg <= press_ticks_next;
            phase_reg       <= phase_next;
            debounce_reg    <= debounce_next;
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_width_reg <= width_next;
            out_level_reg <= level_next;
            out_busy_reg  <= (phase_next != sslvl_pkg::PHASE_IDLE);
        end
    end

    // The level never leaves the range off to four.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= sslvl_pkg::LEVEL_FOUR)
        else $error("power level out of range");

    // While the button stays held after an accepted press the level cannot change.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == sslvl_pkg::PHASE_AWAIT && button.button_pressed
        |=> level_reg == $past(level_reg))
        else $error("level changed while awaiting release");

    // Entering the await phase from debounce restarts the auto-off count.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == sslvl_pkg::PHASE_DEBOUNCE
        && phase_next == sslvl_pkg::PHASE_AWAIT |=> press_ticks_reg == '0)
        else $error("press count not restarted on accepted press");

    // An empty output register always lets an item in.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> button.ready)
        else $error("input stalled with empty output register");

    // The busy flag of a fresh result follows the stored phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_busy_reg == (phase_reg != sslvl_pkg::PHASE_IDLE))
        else $error("busy flag does not match press phase");

endmodule
